[rtl/sseq_pkg.sv]
`default_nettype none
// ============================================================================
// sseq_pkg: shared types and constants of the step sequencer event engine
// Field widths, register indexes, action and event codes, the step entry
// layout and the command and status types between controller and datapath.
// ============================================================================
package sseq_pkg;

	// Configuration port.
	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 2'd2;

	localparam int SPS_W = 28;
	localparam int LEN_W = 7;
	localparam int SMF_W = 16;
	localparam logic [SPS_W-1:0] SPS_RESET = 28'd1536000;
	localparam logic [LEN_W-1:0] LEN_RESET = 7'd16;
	localparam logic [SMF_W-1:0] SMF_RESET = 16'd65208;
	localparam logic [SPS_W-1:0] ONE_SAMPLE = 28'd256;

	// Input item fields.
	localparam int ACT_W   = 2;
	localparam int SIDX_W  = 6;
	localparam int NOTE_W  = 7;
	localparam int VELO_W  = 8;
	localparam int BEND_W  = 14;
	localparam int PROB_W  = 9;
	localparam int RTG_W   = 4;
	localparam int DRAW_W  = 8;

	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_START = 2'd2;
	localparam logic [ACT_W-1:0] ACT_STOP  = 2'd3;

	// Result item fields.
	localparam int KIND_W = 2;
	localparam int VAL_W  = 14;
	localparam int DLY_W  = 20;
	localparam logic [KIND_W-1:0] EV_ON    = 2'd0;
	localparam logic [KIND_W-1:0] EV_OFF   = 2'd1;
	localparam logic [KIND_W-1:0] EV_WHEEL = 2'd2;
	localparam logic [VAL_W-1:0] WHEEL_CENTER = 14'd8192;
	localparam logic [VAL_W-1:0] WHEEL_MAX    = 14'd16383;

	// Internal state widths.
	localparam int POS_W  = 29;
	localparam int CUR_W  = 32;
	localparam int PROD_W = CUR_W + SMF_W + 1;
	localparam int LEN_CMP_W = 9;
	localparam int VEL_W  = 7;

	// Serial divider and retrigger sequencing.
	localparam int DVD_W = 32;
	localparam int DVS_W = 13;
	localparam int N_W   = 5;
	localparam int T_W   = 4;
	localparam int GATE_DIV = 320;
	localparam int AT_SHIFT = 8;
	localparam int VEL_STEPS = 10;

	// Velocity scaling: v*127*(10-t) is below 2^19, and multiplying by
	// ceil(2^31/2550) then dropping 31 bits gives the exact quotient by 2550.
	localparam int VX_W      = 19;
	localparam int VR_W      = 20;
	localparam int VEL_SHIFT = 31;
	localparam logic [VR_W-1:0] VEL_RECIP = 20'd842151;

	localparam int DEF_MAX_STEPS      = 64;
	localparam int DEF_MAX_RETRIGGERS = 8;

	typedef struct packed {
		logic                     active;
		logic [NOTE_W-1:0]        note;
		logic [VELO_W-1:0]        velocity;
		logic signed [BEND_W-1:0] bend;
		logic                     slide;
		logic [PROB_W-1:0]        probability;
		logic [RTG_W-1:0]         retrigger;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_ADVANCE,
		OP_WRAP,
		OP_READ,
		OP_DECIDE,
		OP_SMUL,
		OP_SFIN,
		OP_GATE_GO,
		OP_AT_GO,
		OP_VEL_GO,
		OP_VEL_FIN,
		OP_EMIT_ON,
		OP_EMIT_OFF,
		OP_EMIT_WHEEL
	} dp_op_t;

	typedef struct packed {
		logic tick_go;
		logic pos_ge;
		logic wrap_ge;
		logic fire;
		logic div_done;
		logic vel_skip;
		logic out_free;
		logic last_trig;
		logic wheel_emit;
	} sts_t;

	typedef enum logic [1:0] {
		DST_GATE,
		DST_AT
	} div_dst_t;

endpackage
`default_nettype wire

[rtl/sseq_ram.sv]
`default_nettype none
// ============================================================================
// sseq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module sseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/sseq_div.sv]
`default_nettype none
// ============================================================================
// sseq_div: restoring serial divider
// Produces one quotient bit per cycle; done pulses when the quotient is valid.
// ============================================================================
module sseq_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sseq_pkg::DVD_W-1:0]  dividend,
	input  wire logic [sseq_pkg::DVS_W-1:0]  divisor,
	output logic                             busy,
	output logic                             done,
	output logic      [sseq_pkg::DVD_W-1:0]  quotient
);
	import sseq_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= CNT_W'(DVD_W - 1);
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/sseq_ctrl.sv]
`default_nettype none
// ============================================================================
// sseq_ctrl: sequencing state machine
// Steps the datapath through position update, entry fetch, smoothing,
// retrigger timing divisions and event output.
// ============================================================================
module sseq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sseq_pkg::sts_t  sts,
	output sseq_pkg::dp_op_t     op
);
	import sseq_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_ADV  = 16'b0000_0000_0000_0010,
		S_WRAP = 16'b0000_0000_0000_0100,
		S_RD   = 16'b0000_0000_0000_1000,
		S_DEC  = 16'b0000_0000_0001_0000,
		S_SMUL = 16'b0000_0000_0010_0000,
		S_SFIN = 16'b0000_0000_0100_0000,
		S_GGO  = 16'b0000_0000_1000_0000,
		S_GWT  = 16'b0000_0001_0000_0000,
		S_AGO  = 16'b0000_0010_0000_0000,
		S_AWT  = 16'b0000_0100_0000_0000,
		S_VGO  = 16'b0000_1000_0000_0000,
		S_VWT  = 16'b0001_0000_0000_0000,
		S_ON   = 16'b0010_0000_0000_0000,
		S_OFF  = 16'b0100_0000_0000_0000,
		S_WHL  = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = OP_ACCEPT;
					if (sts.tick_go) begin
						state_d = S_ADV;
					end
				end
			end
			S_ADV: begin
				op      = OP_ADVANCE;
				state_d = sts.pos_ge ? S_WRAP : S_RD;
			end
			S_WRAP: begin
				op = OP_WRAP;
				if (!sts.wrap_ge) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				op      = OP_READ;
				state_d = S_DEC;
			end
			S_DEC: begin
				op      = OP_DECIDE;
				state_d = S_SMUL;
			end
			S_SMUL: begin
				op      = OP_SMUL;
				state_d = S_SFIN;
			end
			S_SFIN: begin
				op      = OP_SFIN;
				state_d = sts.fire ? S_GGO : S_WHL;
			end
			S_GGO: begin
				op      = OP_GATE_GO;
				state_d = S_GWT;
			end
			S_GWT: begin
				if (sts.div_done) begin
					state_d = S_AGO;
				end
			end
			S_AGO: begin
				op      = OP_AT_GO;
				state_d = S_AWT;
			end
			S_AWT: begin
				if (sts.div_done) begin
					state_d = S_VGO;
				end
			end
			S_VGO: begin
				op      = OP_VEL_GO;
				state_d = sts.vel_skip ? S_ON : S_VWT;
			end
			S_VWT: begin
				op      = OP_VEL_FIN;
				state_d = S_ON;
			end
			S_ON: begin
				if (sts.out_free) begin
					op      = OP_EMIT_ON;
					state_d = S_OFF;
				end
			end
			S_OFF: begin
				if (sts.out_free) begin
					op      = OP_EMIT_OFF;
					state_d = sts.last_trig ? S_WHL : S_AGO;
				end
			end
			S_WHL: begin
				if (!sts.wheel_emit) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					op      = OP_EMIT_WHEEL;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

[rtl/sseq_dp.sv]
`default_nettype none
// ============================================================================
// sseq_dp: sequencer datapath
// Configuration registers, step table, play position, glide smoother,
// serial divider for retrigger timing, reciprocal velocity scaling and the
// output register.
// ============================================================================
module sseq_dp #(
	parameter int MAX_STEPS      = sseq_pkg::DEF_MAX_STEPS,
	parameter int MAX_RETRIGGERS = sseq_pkg::DEF_MAX_RETRIGGERS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire sseq_pkg::dp_op_t                     op,
	output sseq_pkg::sts_t                            sts,
	input  wire logic                                 cfg_we,
	input  wire logic        [sseq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [sseq_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic        [sseq_pkg::ACT_W-1:0]    action,
	input  wire logic        [sseq_pkg::SIDX_W-1:0]   step_index,
	input  wire logic                                 step_active,
	input  wire logic        [sseq_pkg::NOTE_W-1:0]   step_note,
	input  wire logic        [sseq_pkg::VELO_W-1:0]   step_velocity,
	input  wire logic signed [sseq_pkg::BEND_W-1:0]   step_bend,
	input  wire logic                                 step_slide,
	input  wire logic        [sseq_pkg::PROB_W-1:0]   step_probability,
	input  wire logic        [sseq_pkg::RTG_W-1:0]    step_retrigger,
	input  wire logic        [sseq_pkg::DRAW_W-1:0]   random_draw,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic             [sseq_pkg::KIND_W-1:0]   event_kind,
	output logic             [sseq_pkg::NOTE_W-1:0]   event_note,
	output logic             [sseq_pkg::VAL_W-1:0]    event_value,
	output logic             [sseq_pkg::DLY_W-1:0]    event_delay,
	output logic                                      last
);
	import sseq_pkg::*;

	localparam int IDX_W = $clog2(MAX_STEPS);
	localparam int CNT_W = IDX_W + 1;

	// Configuration.
	logic [SPS_W-1:0] sps_q;
	logic [LEN_W-1:0] len_q;
	logic [SMF_W-1:0] smf_q;
	logic [SPS_W-1:0] sps_eff;
	logic [LEN_CMP_W-1:0] len_x;
	logic [LEN_CMP_W-1:0] len_c;
	logic [CNT_W-1:0] eff_len;

	// Playback state.
	logic                     playing_q;
	logic [IDX_W-1:0]         step_q;
	logic [CNT_W-1:0]         wrap_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [CUR_W-1:0]  cur_q;
	logic signed [BEND_W-1:0] tgt_q;
	logic [MAX_STEPS-1:0]     valid_q;

	// Per-tick work registers.
	logic [DRAW_W-1:0]        draw_q;
	logic                     vld_rd_q;
	logic                     fire_q;
	logic [NOTE_W-1:0]        note_q;
	logic [VELO_W-1:0]        velo_q;
	logic [N_W-1:0]           n_q;
	logic [T_W-1:0]           t_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0]         wheel_val_q;
	logic                     wheel_emit_q;
	logic [DLY_W-1:0]         gate_q;
	logic [DLY_W-1:0]         at_q;
	logic [VEL_W-1:0]         vel_q;
	logic [VX_W-1:0]          vel_x_q;
	div_dst_t                 dst_q;

	// Output register.
	logic out_valid_q;
	logic out_free;

	// Step table.
	entry_t           wr_entry;
	entry_t           rd_entry;
	entry_t           ent;
	logic             wr_en;
	logic             idx_ok;
	logic [IDX_W-1:0] wr_addr;

	// Divider.
	logic             div_start;
	logic [DVD_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_busy;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	// Combinational helpers.
	logic                     pos_ge;
	logic                     wrap_ge;
	logic                     fire_d;
	logic [N_W-1:0]           n_d;
	logic                     vel_skip;
	logic                     last_trig;
	logic signed [CUR_W-1:0]  tgt_ext;
	logic signed [CUR_W-1:0]  diff;
	logic signed [SMF_W:0]    coef;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] shq;
	logic signed [CUR_W-1:0]  cur_d;
	logic signed [CUR_W:0]    wv;
	logic [CUR_W-17:0]        wq;
	logic [VAL_W-1:0]         wheel_d;
	logic [14:0]              v127;
	logic [T_W-1:0]           vel_mul;
	logic [VX_W+VR_W-1:0]     vel_full;
	logic [VX_W+VR_W-VEL_SHIFT-1:0] vel_quo;

	assign sps_eff = (sps_q < ONE_SAMPLE) ? ONE_SAMPLE : sps_q;
	assign len_x   = LEN_CMP_W'(len_q);
	always_comb begin
		if (len_x == '0) begin
			len_c = LEN_CMP_W'(1);
		end else if (len_x > LEN_CMP_W'(MAX_STEPS)) begin
			len_c = LEN_CMP_W'(MAX_STEPS);
		end else begin
			len_c = len_x;
		end
	end
	assign eff_len = CNT_W'(len_c);

	assign pos_ge  = pos_q >= POS_W'(sps_eff);
	assign wrap_ge = wrap_q >= eff_len;

	// Entry fetch: an entry never written reads as all zero.
	assign ent = vld_rd_q ? rd_entry : entry_t'('0);
	assign fire_d = (pos_q[POS_W-1:AT_SHIFT] == '0) && ent.active &&
	                ({1'b0, draw_q} <= ent.probability);
	always_comb begin
		if (ent.retrigger == '0) begin
			n_d = N_W'(1);
		end else if (N_W'(ent.retrigger) > N_W'(MAX_RETRIGGERS)) begin
			n_d = N_W'(MAX_RETRIGGERS);
		end else begin
			n_d = N_W'(ent.retrigger);
		end
	end

	// Glide smoother: target in units of 2^-16 of a wheel step.
	assign tgt_ext = {{(CUR_W-BEND_W-16){tgt_q[BEND_W-1]}}, tgt_q, 16'b0};
	assign diff    = cur_q - tgt_ext;
	assign coef    = {1'b0, smf_q};
	assign rnd     = prod_q + (prod_q[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
	assign shq     = rnd >>> 16;
	assign cur_d   = tgt_ext + $signed(shq[CUR_W-1:0]);
	assign wv      = {cur_d[CUR_W-1], cur_d} + (CUR_W+1)'(536870912);
	assign wq      = wv[CUR_W] ? '0 : wv[CUR_W-1:16];
	assign wheel_d = (wq > (CUR_W-16)'(WHEEL_MAX)) ? WHEEL_MAX : VAL_W'(wq);

	assign vel_skip  = t_q >= T_W'(VEL_STEPS);
	assign vel_mul   = T_W'(VEL_STEPS) - t_q;
	assign v127      = {velo_q, 7'b0} - {7'b0, velo_q};
	assign last_trig = (N_W'(t_q) + N_W'(1)) == n_q;

	// Quotient by 2550 through the reciprocal, taken in the cycle after the product is registered.
	assign vel_full = (VX_W+VR_W)'(vel_x_q) * (VX_W+VR_W)'(VEL_RECIP);
	assign vel_quo  = vel_full[VX_W+VR_W-1:VEL_SHIFT];

	assign out_free = !out_valid_q || out_ready;

	// Step table write.
	assign idx_ok   = LEN_CMP_W'(step_index) < LEN_CMP_W'(MAX_STEPS);
	assign wr_addr  = IDX_W'(step_index);
	assign wr_en    = (op == OP_ACCEPT) && (action == ACT_WRITE) && idx_ok;
	assign wr_entry = '{active: step_active, note: step_note, velocity: step_velocity,
	                    bend: step_bend, slide: step_slide,
	                    probability: step_probability, retrigger: step_retrigger};

	sseq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_STEPS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.re    (op == OP_READ),
		.raddr (step_q),
		.rdata (rd_entry)
	);

	// Divider operand selection.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = DVS_W'(1);
		priority if (op == OP_GATE_GO) begin
			div_start    = 1'b1;
			div_dividend = DVD_W'(sps_eff);
			div_divisor  = DVS_W'(n_q) * DVS_W'(GATE_DIV);
		end else if (op == OP_AT_GO) begin
			div_start    = 1'b1;
			div_dividend = DVD_W'(t_q) * DVD_W'(sps_eff);
			div_divisor  = DVS_W'(n_q) << AT_SHIFT;
		end else begin
			div_start = 1'b0;
		end
	end

	sseq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration and playback state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q       <= SPS_RESET;
			len_q       <= LEN_RESET;
			smf_q       <= SMF_RESET;
			playing_q   <= 1'b0;
			step_q      <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			tgt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SPS:    sps_q <= cfg_data[SPS_W-1:0];
					REG_LEN:    len_q <= cfg_data[LEN_W-1:0];
					REG_SMOOTH: smf_q <= cfg_data[SMF_W-1:0];
					default: begin
					end
				endcase
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			unique case (op)
				OP_ACCEPT: begin
					if ((action == ACT_START) || (action == ACT_STOP)) begin
						playing_q <= (action == ACT_START);
						step_q    <= '0;
						pos_q     <= '0;
					end
				end
				OP_ADVANCE: begin
					if (pos_ge) begin
						pos_q <= pos_q - POS_W'(sps_eff);
					end
				end
				OP_WRAP: begin
					if (!wrap_ge) begin
						step_q <= IDX_W'(wrap_q);
					end
				end
				OP_DECIDE: begin
					if (fire_d && ent.slide) begin
						tgt_q <= ent.bend;
					end
				end
				OP_SFIN: begin
					cur_q <= cur_d;
					pos_q <= pos_q + POS_W'(ONE_SAMPLE);
				end
				default: begin
				end
			endcase
			if ((op == OP_EMIT_ON) || (op == OP_EMIT_OFF) || (op == OP_EMIT_WHEEL)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers and output payload.
	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (dst_q)
				DST_GATE: gate_q <= div_quo[DLY_W-1:0];
				DST_AT:   at_q   <= div_quo[DLY_W-1:0];
				default: begin
				end
			endcase
		end
		unique case (op)
			OP_ACCEPT: begin
				draw_q <= random_draw;
			end
			OP_ADVANCE: begin
				wrap_q <= CNT_W'(step_q) + CNT_W'(1);
			end
			OP_WRAP: begin
				if (wrap_ge) begin
					wrap_q <= wrap_q - eff_len;
				end
			end
			OP_READ: begin
				vld_rd_q <= valid_q[step_q];
			end
			OP_DECIDE: begin
				fire_q <= fire_d;
				note_q <= ent.note;
				velo_q <= ent.velocity;
				n_q    <= n_d;
				t_q    <= '0;
			end
			OP_SMUL: begin
				prod_q <= diff * coef;
			end
			OP_SFIN: begin
				wheel_val_q  <= wheel_d;
				wheel_emit_q <= wheel_d != WHEEL_CENTER;
			end
			OP_GATE_GO: begin
				dst_q <= DST_GATE;
			end
			OP_AT_GO: begin
				dst_q <= DST_AT;
			end
			OP_VEL_GO: begin
				if (vel_skip) begin
					vel_q <= VEL_W'(1);
				end else begin
					vel_x_q <= VX_W'(v127) * VX_W'(vel_mul);
				end
			end
			OP_VEL_FIN: begin
				if (vel_quo == '0) begin
					vel_q <= VEL_W'(1);
				end else if (vel_quo > (VX_W+VR_W-VEL_SHIFT)'(127)) begin
					vel_q <= VEL_W'(127);
				end else begin
					vel_q <= vel_quo[VEL_W-1:0];
				end
			end
			OP_EMIT_ON: begin
				event_kind  <= EV_ON;
				event_note  <= note_q;
				event_value <= VAL_W'(vel_q);
				event_delay <= at_q;
				last        <= 1'b0;
			end
			OP_EMIT_OFF: begin
				event_kind  <= EV_OFF;
				event_note  <= note_q;
				event_value <= '0;
				event_delay <= at_q + gate_q;
				last        <= last_trig && !wheel_emit_q;
				t_q         <= t_q + T_W'(1);
			end
			OP_EMIT_WHEEL: begin
				event_kind  <= EV_WHEEL;
				event_note  <= '0;
				event_value <= wheel_val_q;
				event_delay <= '0;
				last        <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	assign sts = '{tick_go:    (action == ACT_TICK) && playing_q,
	               pos_ge:     pos_ge,
	               wrap_ge:    wrap_ge,
	               fire:       fire_q,
	               div_done:   div_done,
	               vel_skip:   vel_skip,
	               out_free:   out_free,
	               last_trig:  last_trig,
	               wheel_emit: wheel_emit_q};

	// A new division must never start on top of one in flight.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// An event is loaded only when the output register is free or being drained.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		((op == OP_EMIT_ON) || (op == OP_EMIT_OFF) || (op == OP_EMIT_WHEEL)) |-> out_free)
		else $error("event overwrote an undelivered event");

	// A centered wheel is never sent.
	a_wheel_off_center: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT_WHEEL) |=> (event_value != WHEEL_CENTER))
		else $error("centered pitch wheel emitted");

	// Retrigger timing is only computed for a retrigger inside the count.
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_AT_GO) |-> (N_W'(t_q) < n_q))
		else $error("retrigger index past its count");

endmodule
`default_nettype wire

[rtl/step_sequencer_event_engine.sv]
`default_nettype none
// ============================================================================
// step_sequencer_event_engine: sample-clocked step sequencer
// Turns sample ticks into note-on, note-off and pitch-wheel events.
// ============================================================================
// Items are taken one at a time. A write, start or stop item, and a tick while
// stopped, is handled in the accept step alone. A tick while playing goes
// through accept, position update, table read, trigger decision, the smoothing
// multiply and finish and the wheel slot, plus a wrap step when a step boundary
// is crossed and one more for each subtraction of the pattern length (one at
// the end of the pattern; more only once after the pattern length is shortened
// below the current step). When a step fires, the gate length is computed on
// the shared serial divider, one quotient bit per cycle, and then each
// retrigger computes its note delay on the divider, then its velocity, scaled
// by a reciprocal multiply, and then its two events. Every event also waits
// for the output register to be free. The step table needs no clearing pass
// after reset: a valid bit per entry makes a never-written entry read as
// inactive. The last flag marks the final event caused by a tick.
// ============================================================================
module step_sequencer_event_engine #(
	parameter int MAX_STEPS      = sseq_pkg::DEF_MAX_STEPS,
	parameter int MAX_RETRIGGERS = sseq_pkg::DEF_MAX_RETRIGGERS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic        [sseq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [sseq_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic        [sseq_pkg::ACT_W-1:0]     action,
	input  wire logic        [sseq_pkg::SIDX_W-1:0]    step_index,
	input  wire logic                                  step_active,
	input  wire logic        [sseq_pkg::NOTE_W-1:0]    step_note,
	input  wire logic        [sseq_pkg::VELO_W-1:0]    step_velocity,
	input  wire logic signed [sseq_pkg::BEND_W-1:0]    step_bend,
	input  wire logic                                  step_slide,
	input  wire logic        [sseq_pkg::PROB_W-1:0]    step_probability,
	input  wire logic        [sseq_pkg::RTG_W-1:0]     step_retrigger,
	input  wire logic        [sseq_pkg::DRAW_W-1:0]    random_draw,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic             [sseq_pkg::KIND_W-1:0]    event_kind,
	output logic             [sseq_pkg::NOTE_W-1:0]    event_note,
	output logic             [sseq_pkg::VAL_W-1:0]     event_value,
	output logic             [sseq_pkg::DLY_W-1:0]     event_delay,
	output logic                                       last
);
	import sseq_pkg::*;

	// The controller only sequences; every register of the behavior lives
	// in the datapath, which reports back through a status struct.
	dp_op_t op;
	sts_t   sts;

	sseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.op       (op)
	);

	sseq_dp #(
		.MAX_STEPS      (MAX_STEPS),
		.MAX_RETRIGGERS (MAX_RETRIGGERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.action           (action),
		.step_index       (step_index),
		.step_active      (step_active),
		.step_note        (step_note),
		.step_velocity    (step_velocity),
		.step_bend        (step_bend),
		.step_slide       (step_slide),
		.step_probability (step_probability),
		.step_retrigger   (step_retrigger),
		.random_draw      (random_draw),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.event_note       (event_note),
		.event_value      (event_value),
		.event_delay      (event_delay),
		.last             (last)
	);

endmodule
`default_nettype wire
